@@ rtl/core/bqef_pkg.sv @@
// ============================================================================
// bqef_pkg: shared types and constants of the biquad cascade
// Holds the default sizes, the fixed field widths, the register indexes and
// the command bundle that the controller hands to the datapath.
// ============================================================================
package bqef_pkg;

    // Default sizes of the cascade.
    localparam int MAX_SECTIONS_DEF = 8;
    localparam int SAMPLE_BITS_DEF  = 24;
    localparam int COEF_BITS_DEF    = 32;

    // Fixed widths of the arithmetic and of the ports.
    localparam int ACC_BITS     = 64;
    localparam int ERR_BITS     = 32;
    localparam int MUL_A_BITS   = 32;
    localparam int FRAC_W       = 5;
    localparam int SECCNT_W     = 4;
    localparam int CFG_DATA_W   = 5;
    localparam int CFG_IDX_W    = 1;
    localparam int COEF_IDX_W   = 6;
    localparam int NUM_COEFS    = 5;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_FRAC_BITS     = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_SECTION_COUNT = 1'b1;

    // Reset values of the configuration registers.
    localparam logic [FRAC_W-1:0]   FRAC_BITS_RST     = 5'd12;
    localparam logic [SECCNT_W-1:0] SECTION_COUNT_RST = 4'd1;

    // Operand pair presented to the shared multiplier.
    typedef enum logic [2:0] {
        MUL_NONE,
        MUL_E1A1,
        MUL_E2A2,
        MUL_XB0,
        MUL_X1B1,
        MUL_X2B2,
        MUL_Y1A1,
        MUL_Y2A2
    } mul_sel_t;

    // Accumulator operation; load, add and subtract take the product of the previous cycle.
    typedef enum logic [2:0] {
        ACC_NONE,
        ACC_LOAD,
        ACC_ADD,
        ACC_SUB,
        ACC_OFFS,
        ACC_SHIFT
    } acc_op_t;

    // Command bundle from the controller to the datapath.
    typedef struct packed {
        logic     start;
        logic     coef_we;
        logic     rd_en;
        mul_sel_t mul_sel;
        acc_op_t  acc_op;
        logic     sat_wb;
        logic     load_out;
    } dp_cmd_t;

endpackage

@@ rtl/core/bqef_datapath.sv @@
// ============================================================================
// bqef_datapath: coefficient and delay memories with one shared MAC
// Holds the coefficient banks, the per-section delay and error stores, the
// multiplier, the 64-bit accumulator, rounding, saturation and the result
// register. Every step is ordered by the controller.
// ============================================================================
module bqef_datapath
    import bqef_pkg::*;
#(
    parameter int MAX_SECTIONS = MAX_SECTIONS_DEF,
    parameter int SAMPLE_BITS  = SAMPLE_BITS_DEF,
    parameter int COEF_BITS    = COEF_BITS_DEF,
    parameter int SEC_W        = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  dp_cmd_t                       cmd,
    input  logic [SEC_W-1:0]              sec_addr,
    input  logic [FRAC_W-1:0]             frac_bits,
    input  logic signed [SAMPLE_BITS-1:0] sample_in,
    input  logic [COEF_IDX_W-1:0]         coef_index,
    input  logic signed [COEF_BITS-1:0]   coef_value,
    output logic signed [SAMPLE_BITS-1:0] sample_out,
    output logic                          overflow
);

    localparam int PROD_W   = MUL_A_BITS + COEF_BITS;
    localparam int NUM_SLOT = NUM_COEFS * MAX_SECTIONS;
    localparam int SLOT_W   = 3;
    localparam logic [SLOT_W-1:0] SLOT_B0 = 3'd0;
    localparam logic [SLOT_W-1:0] SLOT_B1 = 3'd1;
    localparam logic [SLOT_W-1:0] SLOT_B2 = 3'd2;
    localparam logic [SLOT_W-1:0] SLOT_A1 = 3'd3;
    localparam logic [SLOT_W-1:0] SLOT_A2 = 3'd4;
    localparam logic signed [ACC_BITS-1:0] Y_MAX =
        (64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1;
    localparam logic signed [ACC_BITS-1:0] Y_MIN = -Y_MAX - 64'sd1;

    // Coefficient banks, one per coefficient position, one row per section.
    logic [COEF_BITS-1:0]   coef_mem [NUM_COEFS][MAX_SECTIONS];
    logic [MAX_SECTIONS-1:0] coef_vld_reg;
    logic [COEF_BITS-1:0]   coef_rd_reg [NUM_COEFS];
    logic                   coef_rd_vld_reg;

    // Per-section delay and error stores.
    logic [SAMPLE_BITS-1:0] x1_mem [MAX_SECTIONS];
    logic [SAMPLE_BITS-1:0] x2_mem [MAX_SECTIONS];
    logic [SAMPLE_BITS-1:0] y1_mem [MAX_SECTIONS];
    logic [SAMPLE_BITS-1:0] y2_mem [MAX_SECTIONS];
    logic [ERR_BITS-1:0]    e1_mem [MAX_SECTIONS];
    logic [ERR_BITS-1:0]    e2_mem [MAX_SECTIONS];
    logic [MAX_SECTIONS-1:0] st_vld_reg;
    logic [SAMPLE_BITS-1:0] x1_rd_reg, x2_rd_reg, y1_rd_reg, y2_rd_reg;
    logic [ERR_BITS-1:0]    e1_rd_reg, e2_rd_reg;
    logic                   st_rd_vld_reg;

    // Working registers.
    logic signed [SAMPLE_BITS-1:0] x_reg;
    logic signed [ACC_BITS-1:0]    prod_reg;
    logic signed [ACC_BITS-1:0]    acc_reg;
    logic signed [ERR_BITS-1:0]    err_reg;
    logic                          ovf_reg;
    logic signed [SAMPLE_BITS-1:0] out_sample_reg;
    logic                          out_ovf_reg;

    // Read data with never-written rows reading as zero.
    logic signed [SAMPLE_BITS-1:0] x1_q, x2_q, y1_q, y2_q;
    logic signed [ERR_BITS-1:0]    e1_q, e2_q;
    logic signed [COEF_BITS-1:0]   c_q [NUM_COEFS];

    always_comb begin
        x1_q = st_rd_vld_reg ? signed'(x1_rd_reg) : '0;
        x2_q = st_rd_vld_reg ? signed'(x2_rd_reg) : '0;
        y1_q = st_rd_vld_reg ? signed'(y1_rd_reg) : '0;
        y2_q = st_rd_vld_reg ? signed'(y2_rd_reg) : '0;
        e1_q = st_rd_vld_reg ? signed'(e1_rd_reg) : '0;
        e2_q = st_rd_vld_reg ? signed'(e2_rd_reg) : '0;
        for (int k = 0; k < NUM_COEFS; k++) begin
            c_q[k] = coef_rd_vld_reg ? signed'(coef_rd_reg[k]) : '0;
        end
    end

    // Coefficient slot decode: the section is index / 5, computed as
    // (index * 13) >> 6, which is exact for every 6-bit index.
    logic [9:0]            idx_x13;
    logic [3:0]            wr_quot;
    logic [SLOT_W-1:0]     wr_slot;
    logic [SEC_W-1:0]      wr_sec;
    logic                  wr_in_range;

    always_comb begin
        idx_x13     = 10'(coef_index) * 10'd13;
        wr_quot     = idx_x13[9:6];
        wr_slot     = SLOT_W'(coef_index - 6'(wr_quot * 3'd5));
        wr_sec      = SEC_W'(wr_quot);
        wr_in_range = (9'(coef_index) < 9'(NUM_SLOT));
    end

    // Coefficient write: a row that was never written gets its other
    // positions cleared in the same cycle.
    always_ff @(posedge aclk) begin
        if (cmd.coef_we && wr_in_range) begin
            for (int k = 0; k < NUM_COEFS; k++) begin
                if (wr_slot == SLOT_W'(k)) begin
                    coef_mem[k][wr_sec] <= coef_value;
                end else if (!coef_vld_reg[wr_sec]) begin
                    coef_mem[k][wr_sec] <= '0;
                end
            end
        end
        if (cmd.rd_en) begin
            for (int k = 0; k < NUM_COEFS; k++) begin
                coef_rd_reg[k] <= coef_mem[k][sec_addr];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coef_vld_reg    <= '0;
            coef_rd_vld_reg <= 1'b0;
        end else begin
            if (cmd.coef_we && wr_in_range) begin
                coef_vld_reg[wr_sec] <= 1'b1;
            end
            if (cmd.rd_en) begin
                coef_rd_vld_reg <= coef_vld_reg[sec_addr];
            end
        end
    end

    // Rounding constants for the configured shift.
    logic [ACC_BITS-1:0] offs;
    logic [ERR_BITS-1:0] mask;

    always_comb begin
        offs = (frac_bits == '0) ? '0 : (64'd1 << (frac_bits - 5'd1));
        mask = ERR_BITS'((33'd1 << frac_bits) - 33'd1);
    end

    // Saturation of the shifted accumulator to the sample range.
    logic signed [SAMPLE_BITS-1:0] y_sat;
    logic                          y_clip;

    always_comb begin
        y_clip = 1'b1;
        if (acc_reg > Y_MAX) begin
            y_sat = SAMPLE_BITS'(Y_MAX);
        end else if (acc_reg < Y_MIN) begin
            y_sat = SAMPLE_BITS'(Y_MIN);
        end else begin
            y_sat  = SAMPLE_BITS'(acc_reg);
            y_clip = 1'b0;
        end
    end

    // Section write-back shifts each delay pair by one.
    always_ff @(posedge aclk) begin
        if (cmd.sat_wb) begin
            x1_mem[sec_addr] <= x_reg;
            x2_mem[sec_addr] <= x1_q;
            y1_mem[sec_addr] <= y_sat;
            y2_mem[sec_addr] <= y1_q;
            e1_mem[sec_addr] <= err_reg;
            e2_mem[sec_addr] <= e1_q;
        end
        if (cmd.rd_en) begin
            x1_rd_reg <= x1_mem[sec_addr];
            x2_rd_reg <= x2_mem[sec_addr];
            y1_rd_reg <= y1_mem[sec_addr];
            y2_rd_reg <= y2_mem[sec_addr];
            e1_rd_reg <= e1_mem[sec_addr];
            e2_rd_reg <= e2_mem[sec_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_vld_reg    <= '0;
            st_rd_vld_reg <= 1'b0;
        end else begin
            if (cmd.sat_wb) begin
                st_vld_reg[sec_addr] <= 1'b1;
            end
            if (cmd.rd_en) begin
                st_rd_vld_reg <= st_vld_reg[sec_addr];
            end
        end
    end

    // Operand selection for the shared multiplier.
    logic signed [MUL_A_BITS-1:0] mul_a;
    logic signed [COEF_BITS-1:0]  mul_b;
    logic signed [PROD_W-1:0]     mul_p;

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.mul_sel)
            MUL_E1A1: begin
                mul_a = MUL_A_BITS'(e1_q);
                mul_b = c_q[SLOT_A1];
            end
            MUL_E2A2: begin
                mul_a = MUL_A_BITS'(e2_q);
                mul_b = c_q[SLOT_A2];
            end
            MUL_XB0: begin
                mul_a = MUL_A_BITS'(x_reg);
                mul_b = c_q[SLOT_B0];
            end
            MUL_X1B1: begin
                mul_a = MUL_A_BITS'(x1_q);
                mul_b = c_q[SLOT_B1];
            end
            MUL_X2B2: begin
                mul_a = MUL_A_BITS'(x2_q);
                mul_b = c_q[SLOT_B2];
            end
            MUL_Y1A1: begin
                mul_a = MUL_A_BITS'(y1_q);
                mul_b = c_q[SLOT_A1];
            end
            MUL_Y2A2: begin
                mul_a = MUL_A_BITS'(y2_q);
                mul_b = c_q[SLOT_A2];
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        mul_p = mul_a * mul_b;
    end

    always_ff @(posedge aclk) begin
        prod_reg <= ACC_BITS'(mul_p);
    end

    // Accumulator; the wrap of 64-bit two's complement is intended.
    always_ff @(posedge aclk) begin
        case (cmd.acc_op)
            ACC_LOAD:  acc_reg <= prod_reg;
            ACC_ADD:   acc_reg <= acc_reg + prod_reg;
            ACC_SUB:   acc_reg <= acc_reg - prod_reg;
            ACC_OFFS:  acc_reg <= acc_reg + signed'(offs);
            ACC_SHIFT: begin
                acc_reg <= acc_reg >>> frac_bits;
                // Negated rounding error: offset minus the low bits shifted out.
                err_reg <= signed'(offs[ERR_BITS-1:0] - (acc_reg[ERR_BITS-1:0] & mask));
            end
            default: acc_reg <= acc_reg;
        endcase
    end

    // Section input, overflow flag and result register.
    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            x_reg   <= sample_in;
            ovf_reg <= 1'b0;
        end else if (cmd.sat_wb) begin
            x_reg   <= y_sat;
            ovf_reg <= ovf_reg | y_clip;
        end
        if (cmd.load_out) begin
            out_sample_reg <= x_reg;
            out_ovf_reg    <= ovf_reg;
        end
    end

    assign sample_out = out_sample_reg;
    assign overflow   = out_ovf_reg;

endmodule

@@ rtl/core/bqef_ctrl.sv @@
// ============================================================================
// bqef_ctrl: sequencer of the biquad cascade
// Accepts input transfers, steps the shared MAC through each section and
// owns the valid flag of the result register.
// ============================================================================
module bqef_ctrl
    import bqef_pkg::*;
#(
    parameter int MAX_SECTIONS = MAX_SECTIONS_DEF,
    parameter int SEC_W        = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic                s_mode,
    output logic                m_valid,
    input  logic                m_ready,
    input  logic [SECCNT_W-1:0] section_count,
    output dp_cmd_t             cmd,
    output logic [SEC_W-1:0]    sec_addr
);

    typedef enum logic [14:0] {
        S_IDLE    = 15'b000000000000001,
        S_READ    = 15'b000000000000010,
        S_E1      = 15'b000000000000100,
        S_E2      = 15'b000000000001000,
        S_E_ACC   = 15'b000000000010000,
        S_RND0    = 15'b000000000100000,
        S_RND1    = 15'b000000001000000,
        S_B1      = 15'b000000010000000,
        S_B2      = 15'b000000100000000,
        S_A1      = 15'b000001000000000,
        S_A2      = 15'b000010000000000,
        S_A_ACC   = 15'b000100000000000,
        S_OUT0    = 15'b001000000000000,
        S_OUT1    = 15'b010000000000000,
        S_SAT     = 15'b100000000000000
    } state_t;

    state_t           state_reg, state_next;
    logic [SEC_W-1:0] sec_reg, sec_next;
    logic             out_valid_reg, out_valid_next;
    logic             done_reg, done_next;
    logic [SEC_W-1:0] last_sec;
    logic [7:0]       sc_ext;

    // Last section index: a count of zero acts as one, a count above the
    // cascade length acts as the full cascade.
    always_comb begin
        sc_ext = 8'(section_count);
        if (sc_ext == 8'd0) begin
            last_sec = '0;
        end else if (sc_ext > 8'(MAX_SECTIONS)) begin
            last_sec = SEC_W'(MAX_SECTIONS - 1);
        end else begin
            last_sec = SEC_W'(sc_ext - 8'd1);
        end
    end

    // Sequencing of one section and hand-off to the result register.
    always_comb begin
        state_next     = state_reg;
        sec_next       = sec_reg;
        done_next      = done_reg;
        cmd            = '{start: 1'b0, coef_we: 1'b0, rd_en: 1'b0,
                           mul_sel: MUL_NONE, acc_op: ACC_NONE,
                           sat_wb: 1'b0, load_out: 1'b0};
        s_ready        = 1'b0;

        case (state_reg)
            S_IDLE: begin
                if (done_reg) begin
                    // Finished sample waits for the result register.
                    if (!out_valid_reg || m_ready) begin
                        cmd.load_out = 1'b1;
                        done_next    = 1'b0;
                    end
                end else begin
                    s_ready = 1'b1;
                    if (s_valid) begin
                        if (s_mode) begin
                            cmd.coef_we = 1'b1;
                        end else begin
                            cmd.start  = 1'b1;
                            sec_next   = '0;
                            state_next = S_READ;
                        end
                    end
                end
            end
            S_READ: begin
                cmd.rd_en  = 1'b1;
                state_next = S_E1;
            end
            S_E1: begin
                cmd.mul_sel = MUL_E1A1;
                state_next  = S_E2;
            end
            S_E2: begin
                cmd.mul_sel = MUL_E2A2;
                cmd.acc_op  = ACC_LOAD;
                state_next  = S_E_ACC;
            end
            S_E_ACC: begin
                cmd.acc_op = ACC_ADD;
                state_next = S_RND0;
            end
            S_RND0: begin
                cmd.acc_op = ACC_OFFS;
                state_next = S_RND1;
            end
            S_RND1: begin
                cmd.acc_op  = ACC_SHIFT;
                cmd.mul_sel = MUL_XB0;
                state_next  = S_B1;
            end
            S_B1: begin
                cmd.mul_sel = MUL_X1B1;
                cmd.acc_op  = ACC_ADD;
                state_next  = S_B2;
            end
            S_B2: begin
                cmd.mul_sel = MUL_X2B2;
                cmd.acc_op  = ACC_ADD;
                state_next  = S_A1;
            end
            S_A1: begin
                cmd.mul_sel = MUL_Y1A1;
                cmd.acc_op  = ACC_ADD;
                state_next  = S_A2;
            end
            S_A2: begin
                cmd.mul_sel = MUL_Y2A2;
                cmd.acc_op  = ACC_SUB;
                state_next  = S_A_ACC;
            end
            S_A_ACC: begin
                cmd.acc_op = ACC_SUB;
                state_next = S_OUT0;
            end
            S_OUT0: begin
                cmd.acc_op = ACC_OFFS;
                state_next = S_OUT1;
            end
            S_OUT1: begin
                cmd.acc_op = ACC_SHIFT;
                state_next = S_SAT;
            end
            S_SAT: begin
                cmd.sat_wb = 1'b1;
                if (sec_reg == last_sec) begin
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end else begin
                    sec_next   = sec_reg + 1'b1;
                    state_next = S_READ;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Result valid flag: set on load, cleared by an output transfer.
    always_comb begin
        if (cmd.load_out) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            sec_reg       <= '0;
            out_valid_reg <= 1'b0;
            done_reg      <= 1'b0;
        end else begin
            state_reg     <= state_next;
            sec_reg       <= sec_next;
            out_valid_reg <= out_valid_next;
            done_reg      <= done_next;
        end
    end

    assign m_valid  = out_valid_reg;
    assign sec_addr = sec_reg;

endmodule

@@ rtl/core/biquad_cascade_error_feedback.sv @@
// ============================================================================
// biquad_cascade_error_feedback: DF-I biquad cascade with error feedback
// Top level: configuration registers, sequencer and datapath.
// ============================================================================
// A coefficient transfer (mode 1) is taken in the idle state and gives no
// result. An audio sample (mode 0) runs through the active sections on one
// shared multiply-accumulate unit; each section is a row read, seven
// multiplications overlapped with the accumulator, two rounding passes and
// a saturating write-back, and the input side is busy meanwhile. The result
// sits in an output register, so the next transfer is accepted while it
// waits; only a second finished sample waits for the first to leave.
// Coefficients and delay state read as zero until written, with no clearing
// pass after reset.
module biquad_cascade_error_feedback
    import bqef_pkg::*;
#(
    parameter int MAX_SECTIONS = MAX_SECTIONS_DEF,
    parameter int SAMPLE_BITS  = SAMPLE_BITS_DEF,
    parameter int COEF_BITS    = COEF_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic [CFG_IDX_W-1:0]          cfg_index,
    input  logic [CFG_DATA_W-1:0]         cfg_data,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_mode,
    input  logic signed [SAMPLE_BITS-1:0] s_sample_in,
    input  logic [COEF_IDX_W-1:0]         s_coef_index,
    input  logic signed [COEF_BITS-1:0]   s_coef_value,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [SAMPLE_BITS-1:0] m_sample_out,
    output logic                          m_overflow
);

    localparam int SEC_W = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;

    logic [FRAC_W-1:0]   frac_bits_reg;
    logic [SECCNT_W-1:0] section_count_reg;
    dp_cmd_t             cmd;
    logic [SEC_W-1:0]    sec_addr;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frac_bits_reg     <= FRAC_BITS_RST;
            section_count_reg <= SECTION_COUNT_RST;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_FRAC_BITS:     frac_bits_reg     <= cfg_data[FRAC_W-1:0];
                REG_SECTION_COUNT: section_count_reg <= cfg_data[SECCNT_W-1:0];
                default: begin
                    frac_bits_reg     <= frac_bits_reg;
                end
            endcase
        end
    end

    bqef_ctrl #(
        .MAX_SECTIONS (MAX_SECTIONS),
        .SEC_W        (SEC_W)
    ) u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_mode        (s_mode),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .section_count (section_count_reg),
        .cmd           (cmd),
        .sec_addr      (sec_addr)
    );

    bqef_datapath #(
        .MAX_SECTIONS (MAX_SECTIONS),
        .SAMPLE_BITS  (SAMPLE_BITS),
        .COEF_BITS    (COEF_BITS),
        .SEC_W        (SEC_W)
    ) u_datapath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .sec_addr   (sec_addr),
        .frac_bits  (frac_bits_reg),
        .sample_in  (s_sample_in),
        .coef_index (s_coef_index),
        .coef_value (s_coef_value),
        .sample_out (m_sample_out),
        .overflow   (m_overflow)
    );

endmodule

@@ rtl/core/bqef_checker.sv @@
// ============================================================================
// bqef_checker: port-level checks of the biquad cascade
// Watches the ports of the top level and is attached to it by a bind.
// ============================================================================
module bqef_checker
    import bqef_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_valid,
    input logic                          s_ready,
    input logic                          s_mode,
    input logic                          m_valid,
    input logic                          m_ready,
    input logic signed [SAMPLE_BITS-1:0] m_sample_out,
    input logic                          m_overflow
);

    // A result offered stays offered until its transfer.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result valid dropped before its transfer");

    // A stalled result keeps its payload.
    a_out_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable(m_sample_out) && $stable(m_overflow))
        else $error("result payload changed while stalled");

    // Reset leaves no result pending.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // A sample transfer starts filtering, so the input side stalls next.
    a_busy_after_sample: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && !s_mode |=> !s_ready)
        else $error("input accepted while a sample is in flight");

    // A coefficient transfer never makes a result appear.
    a_coef_no_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_mode && !m_valid |=> !m_valid)
        else $error("result produced by a coefficient transfer");

endmodule

bind biquad_cascade_error_feedback bqef_checker #(
    .SAMPLE_BITS (SAMPLE_BITS)
) u_bqef_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_valid      (s_valid),
    .s_ready      (s_ready),
    .s_mode       (s_mode),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_sample_out (m_sample_out),
    .m_overflow   (m_overflow)
);
